// ----- design/ilist_pkg.sv -----
// Shared types and constants for the indexed list block.
// Command and status codes, cell control struct, FSM states, field widths.
// No dependencies.
package ilist_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CHUNK_W   = 8;

	localparam int CMD_W    = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 4;
	localparam int FOUND_W  = 5;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADIX = 2'd2;

	localparam logic [FOUND_W-1:0] NO_MATCH = 5'h1f;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// ----- design/ilist_cmd_if.sv -----
// Command channel: valid/ready handshake carrying command, value, position.
// Depends on ilist_pkg for field widths.
interface ilist_cmd_if import ilist_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [WORD_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink   (input valid, input command, input value, input position, output ready);
endinterface

// ----- design/ilist_res_if.sv -----
// Result channel: valid/ready handshake carrying read_word, found_at, status, count.
// Depends on ilist_pkg for field widths.
interface ilist_res_if import ilist_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [WORD_W-1:0]  read_word;
	logic signed [FOUND_W-1:0] found_at;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, output read_word, output found_at, output status,
		output count, input ready);
	modport sink   (input valid, input read_word, input found_at, input status,
		input count, output ready);
endinterface

// ----- design/ilist_cell.sv -----
// One list slot: holds a word, shifts from either neighbour, compares with the key.
// Depends on ilist_pkg for the cell control struct.
module ilist_cell import ilist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [WORD_W-1:0] load_word,
	input  logic [WORD_W-1:0] left_word,
	input  logic [WORD_W-1:0] right_word,
	input  logic [WORD_W-1:0] key,
	output logic [WORD_W-1:0] word,
	output logic              match
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			case (ctl.op)
				CELL_LOAD:  word_q <= load_word;
				CELL_LEFT:  word_q <= left_word;
				CELL_RIGHT: word_q <= right_word;
				CELL_CLEAR: word_q <= '0;
				default:    word_q <= word_q;
			endcase
		end
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

// ----- design/indexed_list_insert_delete_search.sv -----
// Top level of the indexed list: row of slot cells, command decode, search scan, result register.
// Depends on ilist_pkg, ilist_cmd_if, ilist_res_if and ilist_cell.
//
//  channel | modport | beat carries
//  --------+---------+-------------------------------------------
//  cmd     | sink    | command, value, position
//  res     | source  | read_word, found_at, status, count
//
// Append, insert, delete, read and unknown codes finish without a scan: the cells shift
// in the cycle of acceptance and the result register loads at the same edge.
// Search goes through a scan state: match bits are latched at acceptance
// and a scanner walks them eight per cycle, stopping at the first hit.
// Reset zeroes every cell and the count. A stalled result holds the next command off.
module indexed_list_insert_delete_search import ilist_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ilist_cmd_if.sink   cmd,
	ilist_res_if.source res
);

	localparam int UW  = $clog2(DEPTH + 1);
	localparam int CW  = (UW > POS_W) ? UW : POS_W;
	localparam int RN  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
	localparam int NCH = (DEPTH + CHUNK_W - 1) / CHUNK_W;
	localparam int SCW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int LW  = $clog2(CHUNK_W);

	state_t state_q, state_d;

	logic [UW-1:0]         used_q;
	logic [NCH*CHUNK_W-1:0] match_q;
	logic [SCW-1:0]        scan_q;

	logic                  out_v_q;
	logic [WORD_W-1:0]     rd_q;
	logic [FOUND_W-1:0]    found_q;
	logic [STATUS_W-1:0]   status_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  in_fire;
	logic                  in_rdy;
	logic                  scan_hit;
	logic                  scan_last;
	logic                  scan_done;
	logic [LW-1:0]         hit_lsb;
	logic [CHUNK_W-1:0]    chunk;

	logic [CW-1:0]         used_ext;
	logic [CW-1:0]         pos_ext;
	logic                  full;
	logic                  pos_ok;
	logic                  del_ok;

	logic [UW-1:0]         used_d;
	logic [STATUS_W-1:0]   status_d;
	logic [WORD_W-1:0]     rd_d;

	logic [WORD_W-1:0]     cell_word  [DEPTH];
	logic                  cell_match [DEPTH];
	cell_ctl_t             cell_ctl   [DEPTH];
	logic [NCH*CHUNK_W-1:0] match_d;

	assign used_ext = CW'(used_q);
	assign pos_ext  = CW'(cmd.position);
	assign full     = (used_q >= UW'(DEPTH));
	assign pos_ok   = (pos_ext < CW'(DEPTH));
	assign del_ok   = (pos_ext < used_ext);
	assign in_fire  = cmd.valid && in_rdy;

	// Slot row and per-slot control
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_l0
			assign left_w = '0;
		end else begin : g_ln
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_rl
			assign right_w = '0;
		end else begin : g_rn
			assign right_w = cell_word[i+1];
		end

		always_comb begin
			cell_ctl[i].op = CELL_HOLD;
			if (in_fire) begin
				case (cmd.command)
					CMD_APPEND: begin
						if (!full && IDX == used_ext) cell_ctl[i].op = CELL_LOAD;
					end
					CMD_INSERT: begin
						if (!full && pos_ok) begin
							if (IDX == pos_ext) begin
								cell_ctl[i].op = CELL_LOAD;
							end else if (pos_ext < used_ext && IDX > pos_ext
								&& IDX <= used_ext) begin
								cell_ctl[i].op = CELL_LEFT;
							end
						end
					end
					CMD_DELETE: begin
						if (del_ok) begin
							if (IDX == used_ext - CW'(1)) begin
								cell_ctl[i].op = CELL_CLEAR;
							end else if (IDX >= pos_ext && IDX < used_ext - CW'(1)) begin
								cell_ctl[i].op = CELL_RIGHT;
							end
						end
					end
					default: cell_ctl[i].op = CELL_HOLD;
				endcase
			end
		end

		ilist_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.load_word  (cmd.value),
			.left_word  (left_w),
			.right_word (right_w),
			.key        (cmd.value),
			.word       (cell_word[i]),
			.match      (cell_match[i])
		);

		// only slots below the length take part in a search
		assign match_d[i] = cell_match[i] && (IDX < used_ext);
	end

	for (genvar j = DEPTH; j < NCH*CHUNK_W; j++) begin : g_pad
		assign match_d[j] = 1'b0;
	end

	// Count, status and read word for the accepted beat
	always_comb begin
		used_d   = used_q;
		status_d = STAT_DONE;
		rd_d     = '0;
		case (cmd.command)
			CMD_APPEND: begin
				if (full) status_d = STAT_FULL;
				else      used_d   = used_q + UW'(1);
			end
			CMD_INSERT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else if (!pos_ok) begin
					status_d = STAT_BADIX;
				end else if (pos_ext >= used_ext) begin
					used_d = UW'(pos_ext + CW'(1));
				end else begin
					used_d = used_q + UW'(1);
				end
			end
			CMD_DELETE: begin
				if (!del_ok) status_d = STAT_BADIX;
				else         used_d   = used_q - UW'(1);
			end
			CMD_READ: begin
				if (!pos_ok) status_d = STAT_BADIX;
				for (int k = 0; k < RN; k++) begin
					if (cmd.position == POS_W'(k)) rd_d = cell_word[k];
				end
			end
			default: used_d = used_q;
		endcase
	end

	// Search scan over the latched match bits
	assign chunk     = match_q[scan_q*CHUNK_W +: CHUNK_W];
	assign scan_hit  = |chunk;
	assign scan_last = (scan_q == SCW'(NCH - 1));

	always_comb begin
		hit_lsb = '0;
		for (int b = CHUNK_W - 1; b >= 0; b--) begin
			if (chunk[b]) hit_lsb = LW'(b);
		end
	end

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && cmd.command == CMD_SEARCH) state_d = ST_SCAN;
			ST_SCAN: if (scan_hit || scan_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_rdy    = 1'b0;
		scan_done = 1'b0;
		case (state_q)
			ST_IDLE: in_rdy    = !out_v_q || res.ready;
			ST_SCAN: scan_done = scan_hit || scan_last;
			default: in_rdy    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			scan_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) used_q <= used_d;
			if (in_fire) scan_q <= '0;
			else if (state_q == ST_SCAN && !scan_done) scan_q <= scan_q + SCW'(1);
			if ((in_fire && cmd.command != CMD_SEARCH) || scan_done) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) match_q <= match_d;
		if (in_fire && cmd.command != CMD_SEARCH) begin
			rd_q     <= rd_d;
			found_q  <= NO_MATCH;
			status_q <= status_d;
			count_q  <= COUNT_W'(used_d);
		end else if (scan_done) begin
			rd_q     <= '0;
			found_q  <= scan_hit ? FOUND_W'({scan_q, hit_lsb}) : NO_MATCH;
			status_q <= STAT_DONE;
			count_q  <= COUNT_W'(used_q);
		end
	end

	assign cmd.ready     = in_rdy;
	assign res.valid     = out_v_q;
	assign res.read_word = rd_q;
	assign res.found_at  = found_q;
	assign res.status    = status_q;
	assign res.count     = count_q;

endmodule
